>>> src/tlef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlef_pkg
// shared types and constants of the line-number and escape filter
// ----------------------------------------------------------------------------
package tlef_pkg;

	// decimal digits of the line number prefix
	localparam int NUMBER_DIGITS = 6;
	// prefix is the digits plus one tab
	localparam int PFX_LEN = NUMBER_DIGITS + 1;
	// longest escape sequence of one byte
	localparam int ESC_MAX = 4;
	localparam int ESC_LEN_W = $clog2(ESC_MAX + 1);
	localparam int MAX_LEN = PFX_LEN + ESC_MAX;
	localparam int IDX_W = $clog2(MAX_LEN);

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// register indexes
	localparam logic [2:0] REG_NUMBER_NONBLANK = 3'd0;
	localparam logic [2:0] REG_NUMBER_ALL = 3'd1;
	localparam logic [2:0] REG_SQUEEZE_BLANK = 3'd2;
	localparam logic [2:0] REG_SHOW_TABS = 3'd3;
	localparam logic [2:0] REG_SHOW_ENDS = 3'd4;
	localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd5;

	// characters
	localparam logic [7:0] CH_NL = 8'd10;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_DEL = 8'd127;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_CARET = 8'h5e;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_QMARK = 8'h3f;
	localparam logic [7:0] CH_M = 8'h4d;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CARET_OFFSET = 8'd64;
	localparam logic [7:0] CTRL_LIMIT = 8'd32;
	localparam logic [7:0] HIGH_LIMIT = 8'd160;

	typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_t;

	localparam bcd_t BCD_ONE = bcd_t'(1);

	typedef struct packed {
		logic number_nonblank;
		logic number_all;
		logic squeeze_blank;
		logic show_tabs;
		logic show_ends;
		logic show_nonprinting;
	} cfg_t;

	// one expanded request: optional prefix, then one to four escape bytes
	typedef struct packed {
		logic                             pfx;
		logic [NUMBER_DIGITS-1:0][7:0]    digits;
		logic [ESC_MAX-1:0][7:0]          esc;
		logic [ESC_LEN_W-1:0]             esc_len;
	} rec_t;

endpackage
`default_nettype wire

>>> src/tlef_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlef_cfg
// apb register bank holding the six option bits
// ----------------------------------------------------------------------------
module tlef_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [tlef_pkg::ADDR_W-1:0] paddr,
	input  wire logic [tlef_pkg::DATA_W-1:0] pwdata,
	output logic      [tlef_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output tlef_pkg::cfg_t                  cfg
);
	import tlef_pkg::*;

	cfg_t        cfg_q;
	logic        wr_en;
	logic [2:0]  reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_NUMBER_NONBLANK: cfg_q.number_nonblank <= pwdata[0];
				REG_NUMBER_ALL: cfg_q.number_all <= pwdata[0];
				REG_SQUEEZE_BLANK: cfg_q.squeeze_blank <= pwdata[0];
				REG_SHOW_TABS: cfg_q.show_tabs <= pwdata[0];
				REG_SHOW_ENDS: cfg_q.show_ends <= pwdata[0];
				REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_NUMBER_NONBLANK: prdata[0] = cfg_q.number_nonblank;
			REG_NUMBER_ALL: prdata[0] = cfg_q.number_all;
			REG_SQUEEZE_BLANK: prdata[0] = cfg_q.squeeze_blank;
			REG_SHOW_TABS: prdata[0] = cfg_q.show_tabs;
			REG_SHOW_ENDS: prdata[0] = cfg_q.show_ends;
			REG_SHOW_NONPRINTING: prdata[0] = cfg_q.show_nonprinting;
			default: prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> src/tlef_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlef_front
// line state, numbering and escape expansion into a request record
// ----------------------------------------------------------------------------
module tlef_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  tlef_pkg::cfg_t      cfg,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [7:0]     s_tdata,
	input  wire logic           s_tuser,
	output logic                rec_valid,
	output tlef_pkg::rec_t      rec,
	input  wire logic           rec_take
);
	import tlef_pkg::*;

	bcd_t        cnt_q;
	logic [1:0]  blank_q;
	logic        start_q;
	logic        rec_valid_s1;
	rec_t        rec_s1;

	bcd_t        cnt_in;
	bcd_t        cnt_inc;
	bcd_t        cnt_n;
	logic [1:0]  blank_in;
	logic [1:0]  blank_n;
	logic        start_in;
	logic        start_n;
	logic        sq_hit;
	logic        drop;
	logic        num;
	logic        all_nine;
	logic        carry;
	logic        lead;
	logic [7:0]  c;
	logic        accept;
	rec_t        rec_n;

	assign c = s_tdata;
	assign s_tready = !rec_valid_s1 || rec_take;
	assign accept = s_tvalid && s_tready;
	assign rec_valid = rec_valid_s1;
	assign rec = rec_s1;

	// file start clears line state before the byte is looked at
	assign cnt_in = s_tuser ? BCD_ONE : cnt_q;
	assign blank_in = s_tuser ? 2'd0 : blank_q;
	assign start_in = s_tuser ? 1'b1 : start_q;

	// saturating bcd increment
	always_comb begin
		all_nine = 1'b1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (cnt_in[i] != 4'd9) all_nine = 1'b0;
		end
		cnt_inc = cnt_in;
		carry = 1'b1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (carry) begin
				if (cnt_in[i] >= 4'd9) begin
					cnt_inc[i] = 4'd0;
				end else begin
					cnt_inc[i] = cnt_in[i] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (all_nine) cnt_inc = cnt_in;
	end

	always_comb begin
		sq_hit = cfg.squeeze_blank && (c == CH_NL) && start_in;
		if (sq_hit) begin
			blank_n = (blank_in == 2'd2) ? 2'd2 : blank_in + 2'd1;
		end else begin
			blank_n = 2'd0;
		end
		drop = sq_hit && (blank_n > 2'd1);
		num = start_in && ((cfg.number_nonblank && (c != CH_NL)) ||
			(cfg.number_all && !cfg.number_nonblank));
		if (drop) begin
			start_n = 1'b1;
			cnt_n = cnt_in;
		end else begin
			start_n = (c == CH_NL);
			cnt_n = num ? cnt_inc : cnt_in;
		end
	end

	// record build: space-padded digits, then the escape bytes
	always_comb begin
		rec_n = '0;
		rec_n.pfx = num;
		lead = 1'b1;
		for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
			if (cnt_in[i] != 4'd0 || i == 0) lead = 1'b0;
			rec_n.digits[NUMBER_DIGITS-1-i] = lead ? CH_SPACE : (CH_ZERO + {4'd0, cnt_in[i]});
		end
		if (cfg.show_tabs && c == CH_TAB) begin
			rec_n.esc[0] = CH_CARET;
			rec_n.esc[1] = CH_I;
			rec_n.esc_len = ESC_LEN_W'(2);
		end else if (c == CH_NL) begin
			if (cfg.show_ends) begin
				rec_n.esc[0] = CH_DOLLAR;
				rec_n.esc[1] = CH_NL;
				rec_n.esc_len = ESC_LEN_W'(2);
			end else begin
				rec_n.esc[0] = CH_NL;
				rec_n.esc_len = ESC_LEN_W'(1);
			end
		end else if (cfg.show_nonprinting && c == CH_DEL) begin
			rec_n.esc[0] = CH_CARET;
			rec_n.esc[1] = CH_QMARK;
			rec_n.esc_len = ESC_LEN_W'(2);
		end else if (cfg.show_nonprinting && c < CTRL_LIMIT && c != CH_TAB) begin
			rec_n.esc[0] = CH_CARET;
			rec_n.esc[1] = c + CARET_OFFSET;
			rec_n.esc_len = ESC_LEN_W'(2);
		end else if (cfg.show_nonprinting && c > CH_DEL && c < HIGH_LIMIT) begin
			rec_n.esc[0] = CH_M;
			rec_n.esc[1] = CH_DASH;
			rec_n.esc[2] = CH_CARET;
			rec_n.esc[3] = c - CARET_OFFSET;
			rec_n.esc_len = ESC_LEN_W'(4);
		end else begin
			rec_n.esc[0] = c;
			rec_n.esc_len = ESC_LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= BCD_ONE;
			blank_q <= 2'd0;
			start_q <= 1'b1;
			rec_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_n;
				blank_q <= blank_n;
				start_q <= start_n;
			end
			if (accept && !drop) begin
				rec_valid_s1 <= 1'b1;
			end else if (rec_take) begin
				rec_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !drop) rec_s1 <= rec_n;
	end

endmodule
`default_nettype wire

>>> src/tlef_ser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlef_ser
// walks a request record one byte at a time into the output register
// ----------------------------------------------------------------------------
module tlef_ser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rec_valid,
	input  tlef_pkg::rec_t   rec,
	output logic             rec_take,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);
	import tlef_pkg::*;

	logic [IDX_W-1:0] pos_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] idx_end;
	logic [7:0]       cur_byte;
	logic             cur_last;
	logic             out_load;

	assign out_load = !out_valid_q || m_tready;
	assign idx = (rec.pfx ? '0 : IDX_W'(PFX_LEN)) + pos_q;
	assign idx_end = IDX_W'(PFX_LEN) + IDX_W'(rec.esc_len) - IDX_W'(1);
	assign cur_last = (idx == idx_end);
	assign rec_take = out_load && rec_valid && cur_last;

	always_comb begin
		cur_byte = '0;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (idx == IDX_W'(i)) cur_byte = rec.digits[i];
		end
		if (idx == IDX_W'(NUMBER_DIGITS)) cur_byte = CH_TAB;
		for (int i = 0; i < ESC_MAX; i++) begin
			if (idx == IDX_W'(PFX_LEN + i)) cur_byte = rec.esc[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= rec_valid;
			if (rec_valid) pos_q <= cur_last ? '0 : pos_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && rec_valid) begin
			out_byte_q <= cur_byte;
			out_last_q <= cur_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_byte_q;
	assign m_tlast = out_last_q;

endmodule
`default_nettype wire

>>> src/text_line_number_escape_filter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_number_escape_filter_top
// text filter: line numbers, blank-line squeeze and caret escapes
// ----------------------------------------------------------------------------
// usage
//   s_* stream carries one input byte per request, s_tuser flags the first
//   byte of a new file. m_* stream carries the output bytes; m_tlast marks
//   the last output byte caused by one input byte. a squeezed empty line
//   makes no output at all.
//   the apb port holds six option bits, register i at byte address 4*i;
//   write only while the filter is idle.
// timing
//   an input byte is expanded in the cycle it is taken and held as one
//   record; its first output byte passes through the record register and
//   then the output register. the output moves one byte per cycle while
//   m_tready is high; a byte expands into 1 to 11 output bytes, and the
//   next input byte is taken as its last byte is loaded. plain bytes
//   stream at one per cycle; the output byte walker sets this rate.
// reset and stall
//   reset clears the options, sets the line number to one and marks line
//   start. when m_tready is low the output byte holds and one more record
//   is buffered, then s_tready drops until the record drains.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input stream
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,   // text_byte
	input  wire logic                        s_tuser,   // file_start
	// output stream
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [7:0]                       m_tdata,   // out_byte
	output logic                             m_tlast,   // run_end
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tlef_pkg::ADDR_W-1:0] paddr,
	input  wire logic [tlef_pkg::DATA_W-1:0] pwdata,
	output logic      [tlef_pkg::DATA_W-1:0] prdata,
	output logic                             pready
);
	import tlef_pkg::*;

	cfg_t  cfg;
	rec_t  rec;
	logic  rec_valid;
	logic  rec_take;

	// option registers
	tlef_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// line state and expansion into a record register
	tlef_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.rec_valid (rec_valid),
		.rec       (rec),
		.rec_take  (rec_take)
	);

	// record to output byte stream
	tlef_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec       (rec),
		.rec_take  (rec_take),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire
